FILE: rtl/core/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Types, constants and stage functions of the RGB to HSV converter pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

   // scale and hue circle constants
   localparam logic [7:0] HSV_FULL_SCALE = 8'd255;
   localparam logic [7:0] HUE_SECTOR     = 8'd43;
   localparam logic [7:0] HUE_BASE_RED   = 8'd0;
   localparam logic [7:0] HUE_BASE_GREEN = 8'd85;
   localparam logic [7:0] HUE_BASE_BLUE  = 8'd171;

   // one quotient bit per divider stage, quotients fit in a byte
   localparam int DIV_STEPS   = 8;
   // front stage, divider load stage, divider steps, output stage
   localparam int STAGE_COUNT = DIV_STEPS + 3;

   // max/min and channel difference of one pixel
   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] span;
      logic [7:0] base;
      logic       neg;
      logic [7:0] abs_diff;
   } rhc_front_type;

   // state of both dividers travelling down the pipeline
   typedef struct packed {
      logic [7:0] brightness;
      logic [7:0] span;
      logic [7:0] base;
      logic       neg;
      logic [7:0] sat_rem;
      logic [7:0] sat_work;
      logic [7:0] hue_rem;
      logic [7:0] hue_work;
   } rhc_div_type;

   // largest and smallest channel, hue sector and signed difference
   function automatic rhc_front_type front_calc(input logic [7:0] red,
                                                input logic [7:0] green,
                                                input logic [7:0] blue);
      rhc_front_type f;
      logic [7:0]    hi;
      logic [7:0]    lo;
      logic [7:0]    x;
      logic [7:0]    y;
      hi = red;
      if (green > hi) hi = green;
      if (blue > hi) hi = blue;
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
      // red wins ties, then green
      if (hi == red) begin
         f.base = HUE_BASE_RED;
         x = green;
         y = blue;
      end else if (hi == green) begin
         f.base = HUE_BASE_GREEN;
         x = blue;
         y = red;
      end else begin
         f.base = HUE_BASE_BLUE;
         x = red;
         y = green;
      end
      f.neg        = (x < y);
      f.abs_diff   = (x < y) ? (y - x) : (x - y);
      f.brightness = hi;
      f.span       = hi - lo;
      return f;
   endfunction

   // form both dividends and split them into remainder and shift word
   function automatic rhc_div_type div_init(input rhc_front_type f);
      rhc_div_type d;
      logic [15:0] sat_num;
      logic [15:0] hue_num;
      sat_num      = 16'(f.span) * 16'(HSV_FULL_SCALE);
      hue_num      = 16'(f.abs_diff) * 16'(HUE_SECTOR);
      d.brightness = f.brightness;
      d.span       = f.span;
      d.base       = f.base;
      d.neg        = f.neg;
      d.sat_rem    = sat_num[15:8];
      d.sat_work   = sat_num[7:0];
      d.hue_rem    = hue_num[15:8];
      d.hue_work   = hue_num[7:0];
      return d;
   endfunction

   // one restoring division step: remainder in the upper byte, shift word below
   function automatic logic [15:0] step_one(input logic [7:0] rem,
                                            input logic [7:0] work,
                                            input logic [7:0] divisor);
      logic [8:0] cand;
      logic [8:0] diff;
      logic       qbit;
      cand = {rem, work[7]};
      diff = cand - {1'b0, divisor};
      qbit = (cand >= {1'b0, divisor});
      return {(qbit ? diff[7:0] : cand[7:0]), work[6:0], qbit};
   endfunction

   // advance both dividers by one quotient bit
   function automatic rhc_div_type div_step(input rhc_div_type s);
      rhc_div_type d;
      logic [15:0] sat_next;
      logic [15:0] hue_next;
      sat_next   = step_one(s.sat_rem, s.sat_work, s.brightness);
      hue_next   = step_one(s.hue_rem, s.hue_work, s.span);
      d          = s;
      d.sat_rem  = sat_next[15:8];
      d.sat_work = sat_next[7:0];
      d.hue_rem  = hue_next[15:8];
      d.hue_work = hue_next[7:0];
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rgb_to_hsv_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Pipelined 8-bit RGB to HSV conversion with a valid/stall stream on both sides.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while req_stall is low and returns one HSV result
// per pixel, in order. The two restoring dividers (255*(max-min)/max and
// 43*|diff|/(max-min)) run side by side over eight stages, one quotient bit
// per stage, after a compare and a multiply stage and before an output stage.
// Every stage holds its own valid bit, so bubbles close up under a stall and
// req_stall rises only when all stages are full and the output is stalled.
// Hue is on a 0..255 circle and wraps; a gray or black pixel gives hue 0.
`default_nettype none

module rgb_to_hsv_converter_core import rhc_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_red,
   input  wire logic [7:0] req_green,
   input  wire logic [7:0] req_blue,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [7:0] rsp_hue,
   output      logic [7:0] rsp_saturation,
   output      logic [7:0] rsp_brightness
);

   localparam int LAST = STAGE_COUNT - 1;

   logic [STAGE_COUNT-1:0] vld_ff;
   logic [STAGE_COUNT-1:0] vld_in;
   logic [STAGE_COUNT-1:0] rdy;

   rhc_front_type front_ff;
   rhc_front_type front_in;
   rhc_div_type   div_ff [DIV_STEPS+1];
   rhc_div_type   div_in [DIV_STEPS+1];

   logic [7:0] hue_ff;
   logic [7:0] hue_in;
   logic [7:0] sat_ff;
   logic [7:0] sat_in;
   logic [7:0] bright_ff;

   // per-stage ready: a stage moves when empty or when the next one moves
   always_comb begin
      rdy[LAST] = !vld_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < STAGE_COUNT; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage functions
   always_comb begin
      front_in  = front_calc(req_red, req_green, req_blue);
      div_in[0] = div_init(front_ff);
      for (int k = 1; k <= DIV_STEPS; k++) begin
         div_in[k] = div_step(div_ff[k-1]);
      end
   end

   // hue: sector base plus signed quotient, gray pixels forced to zero
   always_comb begin
      if (div_ff[DIV_STEPS].span == 8'd0) begin
         hue_in = 8'd0;
         sat_in = 8'd0;
      end else begin
         hue_in = div_ff[DIV_STEPS].neg
                  ? (div_ff[DIV_STEPS].base - div_ff[DIV_STEPS].hue_work)
                  : (div_ff[DIV_STEPS].base + div_ff[DIV_STEPS].hue_work);
         sat_in = div_ff[DIV_STEPS].sat_work;
      end
   end

   // payload registers load on a transfer into their stage
   always_ff @(posedge clock) begin
      if (rdy[0] && req_valid) begin
         front_ff <= front_in;
      end
      for (int k = 0; k <= DIV_STEPS; k++) begin
         if (rdy[k+1] && vld_ff[k]) begin
            div_ff[k] <= div_in[k];
         end
      end
      if (rdy[LAST] && vld_ff[LAST-1]) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= div_ff[DIV_STEPS].brightness;
      end
   end

   // outputs
   assign req_stall      = !rdy[0];
   assign rsp_valid      = vld_ff[LAST];
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

   // input is held off only when every stage is full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (vld_ff == '1))
      else $error("input stalled while pipeline has a free stage");

   // an input transfer always lands in the front stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("input transfer lost at front stage");

   // a black pixel has no saturation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_brightness == 8'd0) |-> (rsp_saturation == 8'd0))
      else $error("nonzero saturation on black pixel");

   // a gray pixel has no hue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturation == 8'd0) |-> (rsp_hue == 8'd0))
      else $error("nonzero hue on gray pixel");

endmodule

`default_nettype wire

FILE: tb/sv/rgb_to_hsv_converter_core_test.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core_test
// Self-checking testbench for the pipelined 8-bit RGB to HSV converter.
// ----------------------------------------------------------------------------
// Pixels go in over the valid/stall request channel. Corner pixels come first,
// then random pixels of several shapes, under random sender gaps and receiver
// stalls. Each input transfer is converted by an independent integer HSV
// calculation and queued. Each result transfer is compared field by field
// against the oldest queued expectation.
`default_nettype none

module rgb_to_hsv_converter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rhc_pkg::STAGE_COUNT;

   // hsv scale and hue circle
   localparam int FULL_SCALE  = 255;
   localparam int SECTOR      = 43;
   localparam int BASE_GREEN  = 85;
   localparam int BASE_BLUE   = 171;

   localparam int ERROR_PRINT_MAX = 100;
   localparam logic [7:0] CORNER_VALUES [4] = '{8'd0, 8'd1, 8'd254, 8'd255};

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } pixel_hsv_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_red   = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue  = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_hue;
   logic [7:0] rsp_saturation;
   logic [7:0] rsp_brightness;

   pixel_hsv_type hsv_pending[$];
   int         error_count     = 0;
   int         pixels_sent     = 0;
   int         results_checked = 0;
   int         gap_max         = 0;
   int         stall_max       = 0;
   int         stall_left      = 0;

   rgb_to_hsv_converter_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // integer hsv of one pixel
   function automatic pixel_hsv_type hsv_of(input logic [7:0] red, input logic [7:0] green,
                                            input logic [7:0] blue);
      pixel_hsv_type p;
      int         r, g, b, hi, lo, span, diff, base, sat, hue;
      r = red;
      g = green;
      b = blue;
      hi = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      sat  = 0;
      hue  = 0;
      // black and gray pixels keep hue and saturation at zero
      if (hi != 0) begin
         sat = (FULL_SCALE * span) / hi;
         if (sat != 0 && span != 0) begin
            // red wins ties, then green
            if (hi == r) begin
               base = 0;
               diff = g - b;
            end else if (hi == g) begin
               base = BASE_GREEN;
               diff = b - r;
            end else begin
               base = BASE_BLUE;
               diff = r - g;
            end
            hue = base + (SECTOR * diff) / span;
         end
      end
      p.red        = red;
      p.green      = green;
      p.blue       = blue;
      p.hue        = hue[7:0];
      p.saturation = sat[7:0];
      p.brightness = hi[7:0];
      return p;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < ERROR_PRINT_MAX)
         $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string field, input logic [7:0] got,
                              input logic [7:0] want, input pixel_hsv_type p);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d for rgb (%0d,%0d,%0d)",
                                   field, got, want, p.red, p.green, p.blue));
   endtask

   // result check, receiver stalls and input transfer capture in one process
   always @(posedge clock) begin : result_check
      pixel_hsv_type want;
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (hsv_pending.size() == 0) begin
               report_mismatch($sformatf("result (%0d,%0d,%0d) with nothing pending",
                                         rsp_hue, rsp_saturation, rsp_brightness));
            end else begin
               want = hsv_pending.pop_front();
               check_field("hue", rsp_hue, want.hue, want);
               check_field("saturation", rsp_saturation, want.saturation, want);
               check_field("brightness", rsp_brightness, want.brightness, want);
            end
            stall_left = $urandom_range(0, stall_max);
         end
         // hold off the result side for the drawn number of cycles
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         // capture accepted pixels
         if (req_valid && !req_stall) begin
            hsv_pending.push_back(hsv_of(req_red, req_green, req_blue));
            pixels_sent++;
         end
      end
   end

   // one pixel transfer after a random gap
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= red;
      req_green <= green;
      req_blue  <= blue;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // random pixel of one of several shapes
   task automatic send_random_pixel();
      logic [7:0] r, g, b, v, m;
      int         kind;
      kind = $urandom_range(0, 5);
      v = 8'($urandom);
      m = 8'($urandom_range(0, v));
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case (kind)
         // near gray, tiny span
         1: begin
            r = v;
            g = v ^ 8'($urandom_range(0, 3));
            b = v ^ 8'($urandom_range(0, 3));
         end
         // tied maximum
         2: begin
            case ($urandom_range(0, 3))
               0: begin r = v; g = v; b = m; end
               1: begin r = v; g = m; b = v; end
               2: begin r = m; g = v; b = v; end
               default: begin r = v; g = v; b = v; end
            endcase
         end
         // one channel dark
         3: begin
            case ($urandom_range(0, 2))
               0: r = 8'd0;
               1: g = 8'd0;
               default: b = 8'd0;
            endcase
         end
         // very dark pixels
         4: begin
            r = 8'($urandom_range(0, 3));
            g = 8'($urandom_range(0, 3));
            b = 8'($urandom_range(0, 3));
         end
         // channel extremes
         5: begin
            r = CORNER_VALUES[2'($urandom_range(0, 3))];
            g = CORNER_VALUES[2'($urandom_range(0, 3))];
            b = CORNER_VALUES[2'($urandom_range(0, 3))];
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // wait until every pending result has arrived
   task automatic wait_for_results();
      do @(posedge clock); while (hsv_pending.size() != 0);
   endtask

   // black, white, gray, primaries, ties, negative differences, hue wrap
   task automatic test_corner_pixels();
      gap_max   = 3;
      stall_max = 3;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd200, 8'd10,  8'd50);
      send_pixel(8'd40,  8'd220, 8'd90);
      send_pixel(8'd60,  8'd30,  8'd240);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd2,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'h55,  8'hAA,  8'h55);
      send_pixel(8'hAA,  8'h55,  8'hAA);
      send_pixel(8'h7F,  8'h80,  8'h81);
      send_pixel(8'd254, 8'd255, 8'd0);
      send_pixel(8'd100, 8'd100, 8'd99);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random_pixels(input int count);
      gap_max   = 10;
      stall_max = 10;
      repeat (count) send_random_pixel();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // one pixel per clock, no stalls anywhere
   task automatic test_streaming(input int count);
      gap_max   = 0;
      stall_max = 0;
      repeat (count) send_random_pixel();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // full input rate against a stalling receiver, fills the pipeline
   task automatic test_backpressure(input int count);
      gap_max   = 0;
      stall_max = 10;
      repeat (count) send_random_pixel();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // empty the pipeline in the middle of a burst, then go on
   task automatic test_drain_and_resume(input int count);
      gap_max   = 10;
      stall_max = 10;
      repeat (count / 3) send_random_pixel();
      req_valid <= 1'b0;
      wait_for_results();
      repeat (count - count / 3) send_random_pixel();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_corner_pixels();
      test_random_pixels(400);
      test_streaming(200);
      test_backpressure(200);
      test_drain_and_resume(150);
      wait_for_results();
      repeat (STAGE_COUNT + 4) @(posedge clock);
      $display("run covered %0d pixels: corners, ties, near gray, dark and random ones",
               pixels_sent);
      $display("under gaps, stalls and full rate; %0d results checked, %0d mismatches",
               results_checked, error_count);
      if (error_count == 0 && hsv_pending.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
